// File: design/mpw_pkg.sv
// ----------------------------------------------------------------------------
// mpw_pkg
// shared types and constants of the u8 max pooling window block
// ----------------------------------------------------------------------------
`default_nettype none

package mpw_pkg;

    localparam int MPW_MAX_ROWS     = 32;
    localparam int MPW_MAX_COLS     = 32;
    localparam int MPW_MAX_CHANNELS = 64;

    localparam int MPW_CFG_W  = 6;
    localparam int MPW_IDX_W  = 6;
    localparam int MPW_BYTE_W = 8;
    localparam int MPW_POS_W  = 12;
    localparam int MPW_CLIP_W = 14;

    localparam int MPW_S_TDATA_W = 32;
    localparam int MPW_M_TDATA_W = 8;

    typedef enum logic [2:0] {
        CFG_SRC_HEIGHT = 3'd0,
        CFG_SRC_WIDTH  = 3'd1,
        CFG_KERNEL_H   = 3'd2,
        CFG_KERNEL_W   = 3'd3,
        CFG_STRIDE_Y   = 3'd4,
        CFG_STRIDE_X   = 3'd5,
        CFG_PAD_Y      = 3'd6,
        CFG_PAD_X      = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_POOL = 1'b1
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_ROW,
        ST_LD_CH,
        ST_LD_WR,
        ST_POS_Y,
        ST_POS_X,
        ST_CLIP,
        ST_BASE_ROW,
        ST_BASE_CH,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// File: design/mpw_ram.sv
// ----------------------------------------------------------------------------
// mpw_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/max_pool_window_u8.sv
// ----------------------------------------------------------------------------
// max_pool_window_u8
// unsigned 8-bit 2d max pooling over a row, column, channel byte store
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one byte into the store; loads outside the
// store are dropped. A pool item (tuser 1) returns the largest byte of the
// clipped window, or 0 with the empty flag. One item is in flight at a time.
// A load forms the store address, then writes. A pool item forms its
// position, clips the window, forms the base address and scans the window
// through the single read port of the store, one cell per cycle; an empty
// window skips the scan. One shared multiply-add unit forms positions and
// store addresses. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_window_u8
    import mpw_pkg::*;
#(
    parameter int MAX_ROWS     = MPW_MAX_ROWS,
    parameter int MAX_COLS     = MPW_MAX_COLS,
    parameter int MAX_CHANNELS = MPW_MAX_CHANNELS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration
    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_addr,
    input  wire logic [MPW_CFG_W-1:0]     i_cfg_wdata,
    // input items
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [MPW_S_TDATA_W-1:0] s_axis_tdata,  // row, col, channel, value, zeros
    input  wire logic                     s_axis_tuser,  // mode
    // result items
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [MPW_M_TDATA_W-1:0]      m_axis_tdata,  // max_value
    output logic                          m_axis_tuser   // window_empty
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UW     = (AW > MPW_POS_W) ? AW : MPW_POS_W;
    localparam int BW_C   = $clog2(MAX_COLS + 1);
    localparam int BW_H   = $clog2(MAX_CHANNELS + 1);
    localparam int BW_M   = (BW_C > BW_H) ? BW_C : BW_H;
    localparam int BW     = (BW_M > MPW_CFG_W) ? BW_M : MPW_CFG_W;
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int SW     = MPW_CLIP_W;

    localparam logic [AW-1:0] CH_STEP  = AW'(MAX_CHANNELS);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_COLS * MAX_CHANNELS);
    localparam logic [SW-1:0] ROWS_S   = SW'(MAX_ROWS);
    localparam logic [SW-1:0] COLS_S   = SW'(MAX_COLS);

    // configuration registers
    logic [MPW_CFG_W-1:0] r_src_height, r_src_width, r_kernel_h, r_kernel_w;
    logic [MPW_CFG_W-1:0] r_stride_y, r_stride_x;
    logic [4:0]           r_pad_y, r_pad_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_height <= MPW_CFG_W'(32);
            r_src_width  <= MPW_CFG_W'(32);
            r_kernel_h   <= MPW_CFG_W'(2);
            r_kernel_w   <= MPW_CFG_W'(2);
            r_stride_y   <= MPW_CFG_W'(2);
            r_stride_x   <= MPW_CFG_W'(2);
            r_pad_y      <= 5'd0;
            r_pad_x      <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_wdata;
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_wdata;
                CFG_KERNEL_H:   r_kernel_h   <= i_cfg_wdata;
                CFG_KERNEL_W:   r_kernel_w   <= i_cfg_wdata;
                CFG_STRIDE_Y:   r_stride_y   <= i_cfg_wdata;
                CFG_STRIDE_X:   r_stride_x   <= i_cfg_wdata;
                CFG_PAD_Y:      r_pad_y      <= i_cfg_wdata[4:0];
                CFG_PAD_X:      r_pad_x      <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [MPW_IDX_W-1:0]  in_row, in_col, in_ch;
    logic [MPW_BYTE_W-1:0] in_value;
    logic                  in_take, in_load_ok;

    assign in_row   = s_axis_tdata[5:0];
    assign in_col   = s_axis_tdata[11:6];
    assign in_ch    = s_axis_tdata[17:12];
    assign in_value = s_axis_tdata[25:18];
    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign in_load_ok = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS)
                     && (32'(in_ch) < MAX_CHANNELS);

    // state
    t_state r_state, n_state;

    logic [MPW_IDX_W-1:0]  r_row_in, r_col_in, r_ch;
    logic [MPW_BYTE_W-1:0] r_value;
    logic [UW-1:0]         r_acc, r_py;
    logic [RW-1:0]         r_row, r_r1;
    logic [CW-1:0]         r_col, r_c0, r_c1;
    logic [AW-1:0]         r_addr, r_row_addr;
    logic                  r_rd_vld;
    logic [MPW_BYTE_W-1:0] r_best;
    logic                  r_empty;
    logic                  r_out_valid;
    logic [MPW_BYTE_W-1:0] r_out_data;
    logic                  r_out_empty;

    // shared multiply-add unit
    logic [UW-1:0]    u_a, u_c, u_res;
    logic [BW-1:0]    u_b;
    logic [UW+BW-1:0] u_prod;

    assign u_prod = u_a * u_b;
    assign u_res  = UW'(u_prod) + u_c;

    // window clipping
    logic signed [SW-1:0] ys, ye, xs, xe, bnd_y, bnd_x, ys_c, ye_c, xs_c, xe_c;
    logic                 win_empty;

    always_comb begin
        ys    = $signed(SW'(r_py[MPW_POS_W-1:0])) - $signed(SW'(r_pad_y));
        ye    = ys + $signed(SW'(r_kernel_h));
        xs    = $signed(SW'(r_acc[MPW_POS_W-1:0])) - $signed(SW'(r_pad_x));
        xe    = xs + $signed(SW'(r_kernel_w));
        bnd_y = (SW'(r_src_height) < ROWS_S) ? $signed(SW'(r_src_height))
                                             : $signed(ROWS_S);
        bnd_x = (SW'(r_src_width) < COLS_S) ? $signed(SW'(r_src_width))
                                            : $signed(COLS_S);
        ye_c  = (ye > bnd_y) ? bnd_y : ye;
        xe_c  = (xe > bnd_x) ? bnd_x : xe;
        ys_c  = (ys < 0) ? '0 : ys;
        xs_c  = (xs < 0) ? '0 : xs;
        win_empty = !(ye_c > ys_c) || !(xe_c > xs_c)
                 || (32'(r_ch) >= MAX_CHANNELS);
    end

    logic col_last, row_last, out_free;

    assign col_last = (r_col + CW'(1)) == r_c1;
    assign row_last = (r_row + RW'(1)) == r_r1;
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (t_mode'(s_axis_tuser) == MODE_POOL) begin
                        n_state = ST_POS_Y;
                    end else if (in_load_ok) begin
                        n_state = ST_LD_ROW;
                    end
                end
            end
            ST_LD_ROW:   n_state = ST_LD_CH;
            ST_LD_CH:    n_state = ST_LD_WR;
            ST_LD_WR:    n_state = ST_IDLE;
            ST_POS_Y:    n_state = ST_POS_X;
            ST_POS_X:    n_state = ST_CLIP;
            ST_CLIP:     n_state = win_empty ? ST_OUT : ST_BASE_ROW;
            ST_BASE_ROW: n_state = ST_BASE_CH;
            ST_BASE_CH:  n_state = ST_SCAN;
            ST_SCAN:     n_state = (col_last && row_last) ? ST_DRAIN : ST_SCAN;
            ST_DRAIN:    n_state = ST_OUT;
            ST_OUT:      n_state = out_free ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // state outputs
    logic ram_we, ram_re;

    always_comb begin
        u_a    = '0;
        u_b    = '0;
        u_c    = '0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        unique case (r_state)
            ST_LD_ROW: begin
                u_a = UW'(r_row_in);
                u_b = BW'(MAX_COLS);
                u_c = UW'(r_col_in);
            end
            ST_LD_CH: begin
                u_a = r_acc;
                u_b = BW'(MAX_CHANNELS);
                u_c = UW'(r_ch);
            end
            ST_LD_WR: ram_we = 1'b1;
            ST_POS_Y: begin
                u_a = UW'(r_row_in);
                u_b = BW'(r_stride_y);
            end
            ST_POS_X: begin
                u_a = UW'(r_col_in);
                u_b = BW'(r_stride_x);
            end
            ST_BASE_ROW: begin
                u_a = UW'(r_row);
                u_b = BW'(MAX_COLS);
                u_c = UW'(r_col);
            end
            ST_BASE_CH: begin
                u_a = r_acc;
                u_b = BW'(MAX_CHANNELS);
                u_c = UW'(r_ch);
            end
            ST_SCAN: ram_re = 1'b1;
            default: ;
        endcase
    end

    // byte store
    logic [MPW_BYTE_W-1:0] ram_q;

    mpw_ram #(
        .WIDTH (MPW_BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_acc[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // datapath
    always_ff @(posedge i_clk) begin
        r_acc <= u_res;
        if (r_state == ST_IDLE && in_take) begin
            r_row_in <= in_row;
            r_col_in <= in_col;
            r_ch     <= in_ch;
            r_value  <= in_value;
        end
        if (r_state == ST_POS_X) begin
            r_py <= r_acc;
        end
        if (r_state == ST_CLIP) begin
            r_row   <= RW'(ys_c);
            r_r1    <= RW'(ye_c);
            r_col   <= CW'(xs_c);
            r_c0    <= CW'(xs_c);
            r_c1    <= CW'(xe_c);
            r_best  <= '0;
            r_empty <= win_empty;
        end
        if (r_state == ST_BASE_CH) begin
            r_addr     <= u_res[AW-1:0];
            r_row_addr <= u_res[AW-1:0];
        end
        if (r_state == ST_SCAN) begin
            if (col_last) begin
                r_col      <= r_c0;
                r_row      <= r_row + RW'(1);
                r_addr     <= r_row_addr + ROW_STEP;
                r_row_addr <= r_row_addr + ROW_STEP;
            end else begin
                r_col  <= r_col + CW'(1);
                r_addr <= r_addr + CH_STEP;
            end
        end
        if (r_rd_vld && (ram_q > r_best)) begin
            r_best <= ram_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= ram_re;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_data  <= r_empty ? '0 : r_best;
            r_out_empty <= r_empty;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_empty;

    // checks
    a_rd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state) == ST_SCAN)
        else $error("store read data without a scan read");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_row < r_r1) && (r_col < r_c1))
        else $error("scan position outside the clipped window");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty window item with nonzero value");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("new item taken while a pool item is in flight");

endmodule

`default_nettype wire
